// ===== hdl/dcbp_pkg.sv =====
// Package for the draw command byte parser: character codes, command codes,
// parser phases and the result word type. No dependencies.
package dcbp_pkg;

  // Default width of the saturating value accumulator.
  localparam int unsigned VALUE_BITS_DEF = 32;
  // Width of the value fields on the result port.
  localparam int unsigned OUT_W = 32;
  // Result queue depth; two free entries are needed to take a byte.
  localparam int unsigned FIFO_DEPTH = 4;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_L  = 8'h4C;
  localparam logic [7:0] CH_UP_M  = 8'h4D;
  localparam logic [7:0] CH_UP_U  = 8'h55;
  localparam logic [7:0] CH_UP_V  = 8'h56;
  localparam logic [7:0] CH_UP_W  = 8'h57;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_L  = 8'h6C;
  localparam logic [7:0] CH_LO_M  = 8'h6D;

  // Command codes as they appear on the result port.
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_MOVE     = 4'd1,
    CMD_MOVE_REL = 4'd2,
    CMD_LINE     = 4'd3,
    CMD_LINE_REL = 4'd4,
    CMD_W        = 4'd5,
    CMD_V        = 4'd6,
    CMD_U        = 4'd7,
    CMD_X        = 4'd8
  } cmd_e;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_CMD     = 2'd0,
    PH_FIRST   = 2'd1,
    PH_SECOND  = 2'd2,
    PH_DISCARD = 2'd3
  } phase_e;

  // One result word.
  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               req;
    logic               last;
  } result_t;

  // Move and line commands: two values, and a path request at line start.
  function automatic logic cmd_is_path(cmd_e c);
    return (c == CMD_MOVE) || (c == CMD_MOVE_REL) ||
           (c == CMD_LINE) || (c == CMD_LINE_REL);
  endfunction

  // Commands that take two values.
  function automatic logic cmd_two_values(cmd_e c);
    return cmd_is_path(c) || (c == CMD_U);
  endfunction

endpackage

// ===== hdl/draw_command_byte_parser_top.sv =====
// Draw command byte parser top level: parser state and a small result queue.
// Depends on dcbp_pkg.
//
// The parser takes one ASCII byte per clock while in_stall_o is low and turns
// plotter command lines into result words (command code, two saturated signed
// values, path request flag, last-of-byte flag). A byte is parsed in the cycle
// it is accepted and its results, at most two, are written into a four-entry
// result queue that feeds the output. A byte is accepted in every cycle while the
// queue has two free entries, so with the output side taking one word per
// cycle the sustained rate is one byte per cycle; a byte that completes a
// command and also yields a result of its own puts two words in the queue,
// and the output port drains them one per cycle while out_stall_i is low.
module draw_command_byte_parser_top
  import dcbp_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         cmd_code_o,
  output logic signed [31:0] x_value_o,
  output logic signed [31:0] y_value_o,
  output logic               request_path_o,
  output logic               last_of_run_o
);

  localparam int unsigned WIDE_W = VALUE_BITS + 4;
  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam logic [VALUE_BITS-1:0] LIM = {1'b1, {(VALUE_BITS - 1){1'b0}}};

  // Parser state.
  phase_e                       phase_q, phase_d;
  cmd_e                         pending_q, pending_d;
  logic                         started_q, started_d;
  logic                         negative_q, negative_d;
  logic                         stopped_q, stopped_d;
  logic [VALUE_BITS-1:0]        mag_q, mag_d;
  logic signed [VALUE_BITS-1:0] first_q, first_d;
  logic                         fresh_q, fresh_d;

  // Result queue.
  result_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;

  logic in_accept, out_accept;
  logic is_digit, is_minus, is_sep, is_lf, is_nul;
  logic [3:0] digit;
  logic [WIDE_W-1:0] wide_mag, acc_sum;
  logic signed [VALUE_BITS-1:0] tok_val;
  logic signed [31:0] a_x, a_y;
  logic emit_a, emit_b, set_fresh, do_cmd;
  cmd_e b_cmd;
  result_t word_a, word_b, push0, push1;
  logic [1:0] n_push;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;

  // Byte classes.
  assign is_digit = (byte_in_i >= CH_ZERO) && (byte_in_i <= CH_NINE);
  assign is_minus = (byte_in_i == CH_MINUS);
  assign is_sep   = (byte_in_i == CH_SPACE) || (byte_in_i == CH_CR);
  assign is_lf    = (byte_in_i == CH_LF);
  assign is_nul   = (byte_in_i == CH_NUL);
  assign digit    = 4'(byte_in_i - CH_ZERO);

  // Next magnitude: ten times the old one plus the digit, as shifts and adds.
  assign wide_mag = WIDE_W'(mag_q);
  assign acc_sum  = (wide_mag << 3) + (wide_mag << 1) + WIDE_W'(digit);

  // Value of the current token, clamped to signed VALUE_BITS.
  always_comb begin
    if (!started_q) begin
      tok_val = '0;
    end else if (negative_q) begin
      tok_val = signed'(~mag_q + 1'b1);
    end else if (mag_q == LIM) begin
      tok_val = signed'(LIM - 1'b1);
    end else begin
      tok_val = signed'(mag_q);
    end
  end

  // Values of a completed command: the first value closes in phase one.
  assign a_x = (phase_q == PH_FIRST) ? 32'(tok_val) : 32'(first_q);
  assign a_y = (phase_q == PH_FIRST) ? '0 : 32'(tok_val);

  // Next parser state and which results this byte gives.
  always_comb begin
    phase_d    = phase_q;
    pending_d  = pending_q;
    started_d  = started_q;
    negative_d = negative_q;
    stopped_d  = stopped_q;
    mag_d      = mag_q;
    first_d    = first_q;
    fresh_d    = fresh_q;
    emit_a     = 1'b0;
    emit_b     = 1'b0;
    b_cmd      = CMD_NONE;
    set_fresh  = 1'b0;
    do_cmd     = 1'b0;
    if (in_accept) begin
      unique case (phase_q) inside
        PH_DISCARD: begin
          if (is_lf) begin
            set_fresh = 1'b1;
            phase_d   = PH_CMD;
          end
        end
        PH_FIRST, PH_SECOND: begin
          if (is_digit || is_minus) begin
            // Extend the token; only a leading minus counts.
            if (!started_q) begin
              started_d = 1'b1;
              if (is_minus) begin
                negative_d = 1'b1;
              end else begin
                mag_d = VALUE_BITS'(digit);
              end
            end else if (!stopped_q) begin
              if (is_minus) begin
                stopped_d = 1'b1;
              end else if (acc_sum > WIDE_W'(LIM)) begin
                mag_d = LIM;
              end else begin
                mag_d = acc_sum[VALUE_BITS-1:0];
              end
            end
          end else begin
            // Any other byte closes the token, except a separator before it.
            if (!is_sep || started_q) begin
              started_d  = 1'b0;
              negative_d = 1'b0;
              stopped_d  = 1'b0;
              mag_d      = '0;
            end
            if (is_sep) begin
              if (started_q) begin
                if ((phase_q == PH_FIRST) && cmd_two_values(pending_q)) begin
                  first_d = tok_val;
                  phase_d = PH_SECOND;
                end else begin
                  emit_a  = 1'b1;
                  phase_d = PH_CMD;
                end
              end
            end else begin
              // Missing values are zero; the command completes here.
              emit_a  = 1'b1;
              phase_d = PH_CMD;
              if (is_lf) begin
                set_fresh = 1'b1;
              end else if (is_nul) begin
                phase_d = PH_DISCARD;
              end else begin
                do_cmd = 1'b1;
              end
            end
          end
        end
        default: begin
          do_cmd = 1'b1;
        end
      endcase

      // Command position.
      if (do_cmd) begin
        unique case (byte_in_i) inside
          CH_SPACE, CH_CR: ;
          CH_LF:   set_fresh = 1'b1;
          CH_NUL:  phase_d = PH_DISCARD;
          CH_UP_X: begin
            emit_b = 1'b1;
            b_cmd  = CMD_X;
          end
          CH_UP_M: begin
            pending_d = CMD_MOVE;
            phase_d   = PH_FIRST;
          end
          CH_LO_M: begin
            pending_d = CMD_MOVE_REL;
            phase_d   = PH_FIRST;
          end
          CH_UP_L: begin
            pending_d = CMD_LINE;
            phase_d   = PH_FIRST;
          end
          CH_LO_L: begin
            pending_d = CMD_LINE_REL;
            phase_d   = PH_FIRST;
          end
          CH_UP_W: begin
            pending_d = CMD_W;
            phase_d   = PH_FIRST;
          end
          CH_UP_V: begin
            pending_d = CMD_V;
            phase_d   = PH_FIRST;
          end
          CH_UP_U: begin
            pending_d = CMD_U;
            phase_d   = PH_FIRST;
          end
          default: begin
            emit_b = 1'b1;
            b_cmd  = CMD_NONE;
          end
        endcase
      end

      // Any result ends the start of line; a newline starts a new one.
      if (set_fresh) begin
        fresh_d = 1'b1;
      end else if (emit_a || emit_b) begin
        fresh_d = 1'b0;
      end
    end
  end

  // Result words of this byte; the completed command comes first.
  always_comb begin
    word_a.cmd  = pending_q;
    word_a.x    = a_x;
    word_a.y    = a_y;
    word_a.req  = fresh_q && cmd_is_path(pending_q);
    word_a.last = !emit_b;
    word_b.cmd  = b_cmd;
    word_b.x    = '0;
    word_b.y    = '0;
    word_b.req  = (b_cmd == CMD_X) || (!emit_a && fresh_q && cmd_is_path(b_cmd));
    word_b.last = 1'b1;
    push0       = emit_a ? word_a : word_b;
    push1       = word_b;
    n_push      = 2'(emit_a) + 2'(emit_b);
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CMD;
      pending_q  <= CMD_NONE;
      started_q  <= 1'b0;
      negative_q <= 1'b0;
      stopped_q  <= 1'b0;
      mag_q      <= '0;
      first_q    <= '0;
      fresh_q    <= 1'b1;
    end else begin
      phase_q    <= phase_d;
      pending_q  <= pending_d;
      started_q  <= started_d;
      negative_q <= negative_d;
      stopped_q  <= stopped_d;
      mag_q      <= mag_d;
      first_q    <= first_d;
      fresh_q    <= fresh_d;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= push0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= push1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PTR_W'(n_push);
      rd_q    <= rd_q + PTR_W'(out_accept);
      count_q <= count_q + CNT_W'(n_push) - CNT_W'(out_accept);
    end
  end

  // Handshake and result ports.
  assign in_stall_o     = (count_q > CNT_W'(FIFO_DEPTH - 2));
  assign out_valid_o    = (count_q != '0);
  assign cmd_code_o     = mem_q[rd_q].cmd;
  assign x_value_o      = mem_q[rd_q].x;
  assign y_value_o      = mem_q[rd_q].y;
  assign request_path_o = mem_q[rd_q].req;
  assign last_of_run_o  = mem_q[rd_q].last;

  // The queue never overflows.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  // A word that is not the last of its byte has its partner queued behind it.
  a_pair_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |-> (count_q >= CNT_W'(2)))
    else $error("first word of a pair without its partner");

  // The token is empty whenever no value is being read.
  a_token_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CMD || phase_q == PH_DISCARD) |-> (!started_q && mag_q == '0))
    else $error("token state left over outside a value");

  // The magnitude never passes its saturation limit.
  a_mag_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= LIM)
    else $error("magnitude beyond saturation limit");

  // While reading values, a command that takes values is pending.
  a_pending_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FIRST || phase_q == PH_SECOND) |->
      (pending_q != CMD_NONE && pending_q != CMD_X))
    else $error("value phase without a command that takes values");

endmodule
